// File: rtl/md5s_pkg.sv
`timescale 1ns / 1ps
// MD5 stream hash: shared types, initial chaining values and round tables.
// No dependencies; imported by md5_stream_hash_core and md5s_round.
package md5s_pkg;

    typedef logic [31:0]      md5s_word_t;
    typedef logic [3:0][31:0] md5s_chain_t;

    typedef struct packed {
        logic start;
        logic init;
    } md5s_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md5s_stat_t;

    localparam int          MD5S_WORDS      = 16;
    localparam logic [7:0]  MD5S_PAD_MARKER = 8'h80;
    localparam logic [5:0]  MD5S_LEN_POS    = 6'd56;
    localparam logic [5:0]  MD5S_LAST_POS   = 6'd63;
    localparam logic [3:0]  MD5S_LEN_BYTES  = 4'd8;
    localparam logic [6:0]  MD5S_FIN_STEP   = 7'd65;

    localparam md5s_chain_t MD5S_INIT = {32'h10325476, 32'h98badcfe,
                                         32'hefcdab89, 32'h67452301};

    function automatic md5s_word_t md5s_k(input logic [5:0] i);
        md5s_word_t k;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // message word used by step i
    function automatic logic [3:0] md5s_g(input logic [5:0] i);
        logic [3:0] n;
        logic [3:0] g;
        n = i[3:0];
        case (i[5:4])
            2'd0:    g = n;
            2'd1:    g = 4'(n * 4'd5 + 4'd1);
            2'd2:    g = 4'(n * 4'd3 + 4'd5);
            default: g = 4'(n * 4'd7);
        endcase
        return g;
    endfunction

    function automatic logic [4:0] md5s_rot(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    function automatic md5s_word_t md5s_rotl(input md5s_word_t v, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

endpackage

// File: rtl/md5s_if.sv
`timescale 1ns / 1ps
// MD5 stream hash: valid/ready channel interfaces for message bytes and digest words.
// No dependencies.
interface md5s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

interface md5s_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// File: rtl/md5_stream_hash_core.sv
`timescale 1ns / 1ps
// MD5 stream hash top level: byte packing, padding sequencer and digest output.
// Depends on md5s_pkg, md5s_if, md5s_ram and md5s_round.
//
//  channel | dir | payload                                   | request taken when
//  msg     | in  | data_byte, byte_present, end_of_message   | valid && ready
//  digest  | out | digest_word, word_index, last_word        | valid && ready
//
// The request that fills a 64-byte block starts one compression (64 steps through
// the word RAM read port, plus start, pipeline and chain add); msg.ready stays
// low meanwhile. Closing a message inserts 9 to 72 padding bytes at one per
// cycle, with one or two compressions, then presents the four digest words in
// turn; digest.ready low holds the current word. Reset needs no clearing pass.
module md5_stream_hash_core
    import md5s_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    md5s_in_if.sink          msg,
    md5s_out_if.source       digest
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_CMP,
        ST_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bit_len_reg, bit_len_next;
    logic        end_pend_reg, end_pend_next;
    logic        marker_reg, marker_next;
    logic [3:0]  len_cnt_reg, len_cnt_next;
    logic [1:0]  idx_reg, idx_next;
    logic        start_reg, start_next;
    logic        init_reg, init_next;
    logic [23:0] word_reg, word_next;

    logic        put_valid;
    logic [7:0]  put_byte;
    logic        ram_we;
    md5s_word_t  ram_wdata;
    logic [3:0]  ram_raddr;
    md5s_word_t  ram_rdata;
    md5s_ctrl_t  ctrl;
    md5s_stat_t  stat;
    md5s_chain_t chain;
    logic        msg_take;
    logic        dig_take;

    assign msg.ready = (state_reg == ST_IDLE);
    assign msg_take  = msg.valid && msg.ready;
    assign dig_take  = digest.valid && digest.ready;

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        bit_len_next  = bit_len_reg;
        end_pend_next = end_pend_reg;
        marker_next   = marker_reg;
        len_cnt_next  = len_cnt_reg;
        idx_next      = idx_reg;
        start_next    = 1'b0;
        init_next     = 1'b0;
        put_valid     = 1'b0;
        put_byte      = 8'h00;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg_take)
                begin
                    end_pend_next = msg.end_of_message;
                    if (msg.byte_present)
                    begin
                        put_valid    = 1'b1;
                        put_byte     = msg.data_byte;
                        bit_len_next = bit_len_reg + 64'd8;
                    end
                    if (msg.byte_present && fill_reg == MD5S_LAST_POS)
                    begin
                        state_next = ST_CMP;
                        start_next = 1'b1;
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                put_valid = 1'b1;
                if (!marker_reg)
                begin
                    put_byte    = MD5S_PAD_MARKER;
                    marker_next = 1'b1;
                end
                else if (len_cnt_reg == 4'd0 && fill_reg != MD5S_LEN_POS)
                begin
                    put_byte = 8'h00;
                end
                else
                begin
                    put_byte     = bit_len_reg[8 * len_cnt_reg[2:0] +: 8];
                    len_cnt_next = len_cnt_reg + 4'd1;
                end
                if (fill_reg == MD5S_LAST_POS)
                begin
                    state_next = ST_CMP;
                    start_next = 1'b1;
                end
            end
            ST_CMP:
            begin
                if (stat.done)
                begin
                    if (!end_pend_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (len_cnt_reg == MD5S_LEN_BYTES)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_OUT:
            begin
                if (dig_take)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        state_next    = ST_IDLE;
                        bit_len_next  = '0;
                        end_pend_next = 1'b0;
                        marker_next   = 1'b0;
                        len_cnt_next  = '0;
                        init_next     = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (put_valid)
        begin
            fill_next = fill_reg + 6'd1;
        end
    end

    // bytes 0..2 of a word wait here; the fourth completes the RAM write
    always_comb
    begin
        word_next = word_reg;
        if (put_valid && fill_reg[1:0] != 2'd3)
        begin
            word_next[8 * fill_reg[1:0] +: 8] = put_byte;
        end
    end

    assign ram_we    = put_valid && (fill_reg[1:0] == 2'd3);
    assign ram_wdata = {put_byte, word_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            bit_len_reg  <= '0;
            end_pend_reg <= 1'b0;
            marker_reg   <= 1'b0;
            len_cnt_reg  <= '0;
            idx_reg      <= '0;
            start_reg    <= 1'b0;
            init_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            bit_len_reg  <= bit_len_next;
            end_pend_reg <= end_pend_next;
            marker_reg   <= marker_next;
            len_cnt_reg  <= len_cnt_next;
            idx_reg      <= idx_next;
            start_reg    <= start_next;
            init_reg     <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign ctrl.start = start_reg;
    assign ctrl.init  = init_reg;

    md5s_ram #(
        .WIDTH (32),
        .DEPTH (MD5S_WORDS)
    ) u_block_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[5:2]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    md5s_round u_round (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .stat    (stat),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata),
        .chain   (chain)
    );

    assign digest.valid       = (state_reg == ST_OUT);
    assign digest.digest_word = chain[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == 2'd3);

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        msg.ready |-> !stat.busy)
        else $error("request accepted during compression");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (!stat.busy && !start_reg))
        else $error("block RAM written during compression");

    a_out_padded: assert property (@(posedge clk) disable iff (!rst_n)
        digest.valid |-> (len_cnt_reg == MD5S_LEN_BYTES && fill_reg == 6'd0))
        else $error("digest presented before padding finished");

    a_clean_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_take && digest.last_word) |=> (fill_reg == 6'd0 && bit_len_reg == 64'd0
                                            && state_reg == ST_IDLE))
        else $error("state not returned to start after digest");

endmodule

// File: rtl/md5s_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module md5s_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/md5s_round.sv
`timescale 1ns / 1ps
// MD5 compression unit: one step per cycle over the block held in the word RAM.
// Depends on md5s_pkg; reads the block RAM owned by the top level.
module md5s_round
    import md5s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  md5s_ctrl_t  ctrl,
    output md5s_stat_t  stat,
    output logic [3:0]  rd_addr,
    input  md5s_word_t  rd_data,
    output md5s_chain_t chain
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    md5s_chain_t chain_reg, chain_next;
    md5s_word_t  a_reg, b_reg, c_reg, d_reg;
    md5s_word_t  a_next, b_next, c_next, d_next;
    logic [5:0]  step;
    md5s_word_t  f;
    md5s_word_t  t;

    // read for step cnt is issued now, its data is used in the next cycle
    assign rd_addr = md5s_g(cnt_reg[5:0]);
    assign step    = 6'(cnt_reg - 7'd1);

    always_comb
    begin
        case (step[5:4])
            2'd0:    f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
    end

    assign t = a_reg + f + md5s_k(step) + rd_data;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        chain_next = chain_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        if (ctrl.init)
        begin
            chain_next = MD5S_INIT;
        end
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = chain_reg[0];
            b_next    = chain_reg[1];
            c_next    = chain_reg[2];
            d_next    = chain_reg[3];
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == MD5S_FIN_STEP)
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                busy_next     = 1'b0;
                done_next     = 1'b1;
            end
            else if (cnt_reg != 7'd0)
            begin
                a_next = d_reg;
                d_next = c_reg;
                c_next = b_reg;
                b_next = b_reg + md5s_rotl(t, md5s_rot(step));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            chain_reg <= MD5S_INIT;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign chain     = chain_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("compression started while busy");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == MD5S_FIN_STEP && !ctrl.start) |=> (done_reg && !busy_reg))
        else $error("final step did not complete the block");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

endmodule
